@@ hdl/pct_pkg.sv @@
// ----------------------------------------------------------------------------
// Pointer contact tracker package
// Field widths, phase and opcode codes, and the layout of one table entry.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int ID_W    = 32;
  localparam int DEV_W   = 4;
  localparam int PHASE_W = 2;
  localparam int POS_W   = 32;
  localparam int DELTA_W = POS_W + 1;
  localparam int PRS_W   = 16;

  localparam logic [PHASE_W-1:0] PH_DOWN   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_MOVE   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_UP     = 2'd2;
  localparam logic [PHASE_W-1:0] PH_CANCEL = 2'd3;

  localparam logic OP_POINTER    = 1'b0;
  localparam logic OP_FOCUS_LOST = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [DEV_W-1:0]        dev;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hdl/pointer_contact_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Pointer contact tracker
// Table of active pointer contacts keyed by contact id and device number.
// ----------------------------------------------------------------------------
// Usage: drive the input word and raise start; it is taken at a clock edge
// where start is high and busy is low. A pointer event sweeps the contact
// table one slot per cycle through a single key comparator, then a shared
// 33-bit subtractor forms delta x and then delta y, and the entry is written
// back. The single result shows in the first cycle with busy low again.
// A focus-lost word sweeps the table the same way and emits one cancel word
// per tracked contact in slot order, at most one per cycle, the final one
// marked by last_result. An empty table emits nothing.
// Each result word is marked by result_strobe and stays on the result ports
// until the next one; the receiver cannot hold it off, so nothing stalls here.
// The sweep through the table memory sets the item time.
// Reset empties the table at once through its valid bits; the memory itself
// needs no clearing pass.
// ----------------------------------------------------------------------------
module pointer_contact_tracker_top
  import pct_pkg::*;
#(
  parameter int MAX_CONTACTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      opcode,
  input  logic [ID_W-1:0]           contact_id,
  input  logic [DEV_W-1:0]          device_kind,
  input  logic [PHASE_W-1:0]        phase,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic [PRS_W-1:0]          pressure,
  output logic                      result_strobe,
  output logic [ID_W-1:0]           out_contact_id,
  output logic [DEV_W-1:0]          out_device,
  output logic [PHASE_W-1:0]        out_phase,
  output logic signed [POS_W-1:0]   out_x,
  output logic signed [POS_W-1:0]   out_y,
  output logic signed [DELTA_W-1:0] delta_x,
  output logic signed [DELTA_W-1:0] delta_y,
  output logic [PRS_W-1:0]          out_pressure,
  output logic                      table_full,
  output logic                      last_result
);

  localparam int N  = MAX_CONTACTS;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(N - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DX    = 5'b00100,
    ST_DY    = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t state;
  logic [N-1:0] valid;

  // Latched input word.
  logic [ID_W-1:0]         id_q;
  logic [DEV_W-1:0]        dev_q;
  logic [PHASE_W-1:0]      ph_q;
  logic signed [POS_W-1:0] x_q;
  logic signed [POS_W-1:0] y_q;
  logic [PRS_W-1:0]        prs_q;

  // Sweep counters.
  logic [CW-1:0] issue_cnt;
  logic          issue_pend;
  logic [AW-1:0] issue_addr;
  logic          cmp_vld;
  logic [AW-1:0] cmp_idx;
  logic          cmp_slot_valid;
  logic          cmp_last;

  // Lookup results.
  logic                    hit_found;
  logic [AW-1:0]           hit_idx;
  logic signed [POS_W-1:0] hit_x;
  logic signed [POS_W-1:0] hit_y;
  logic                    free_found;
  logic [AW-1:0]           free_idx;

  entry_t rd_entry;
  entry_t wr_entry;
  logic   ram_we;
  logic [AW-1:0] ram_waddr;

  logic signed [DELTA_W-1:0] sub_a;
  logic signed [DELTA_W-1:0] sub_b;
  logic signed [DELTA_W-1:0] sub_res;
  logic                      zero_delta;
  logic                      end_phase;
  logic                      key_match;
  logic                      slot_sel;
  logic [N-1:0]              issue_mask;
  logic                      issue_last;

  assign busy       = (state != ST_IDLE);
  assign issue_pend = (issue_cnt < CW'(N));
  assign issue_addr = issue_cnt[AW-1:0];
  assign end_phase  = (ph_q == PH_UP) || (ph_q == PH_CANCEL);
  assign zero_delta = !hit_found || (ph_q == PH_DOWN);
  assign key_match  = (rd_entry.id == id_q) && (rd_entry.dev == dev_q);
  assign slot_sel   = hit_found || (!end_phase && free_found);

  // During a flush the bits below the issued slot are already clear, so the
  // slot is the last one when nothing above it remains.
  assign issue_mask = {{(N-1){1'b0}}, 1'b1} << issue_addr;
  assign issue_last = ((valid & ~issue_mask) == '0);

  // Shared subtractor: x in the first delta cycle, y in the second.
  always_comb begin
    if (state == ST_DX) begin
      sub_a = {x_q[POS_W-1], x_q};
      sub_b = {hit_x[POS_W-1], hit_x};
    end else begin
      sub_a = {y_q[POS_W-1], y_q};
      sub_b = {hit_y[POS_W-1], hit_y};
    end
    sub_res = sub_a - sub_b;
  end

  always_comb begin
    wr_entry.id  = id_q;
    wr_entry.dev = dev_q;
    wr_entry.x   = x_q;
    wr_entry.y   = y_q;
    ram_we       = (state == ST_DY) && slot_sel;
    ram_waddr    = hit_found ? hit_idx : free_idx;
  end

  pct_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(N)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(issue_addr),
    .rdata(rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      result_strobe <= 1'b0;
      cmp_vld       <= 1'b0;
      issue_cnt     <= '0;
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            id_q       <= contact_id;
            dev_q      <= device_kind;
            ph_q       <= phase;
            x_q        <= pos_x;
            y_q        <= pos_y;
            prs_q      <= pressure;
            issue_cnt  <= '0;
            cmp_vld    <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            state      <= (opcode == OP_FOCUS_LOST) ? ST_FLUSH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue_pend) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          cmp_vld <= issue_pend;
          cmp_idx <= issue_addr;
          if (cmp_vld) begin
            if (valid[cmp_idx] && key_match && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= cmp_idx;
              hit_x     <= rd_entry.x;
              hit_y     <= rd_entry.y;
            end
            if (!valid[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST_SLOT) begin
              state <= ST_DX;
            end
          end
        end
        ST_DX: begin
          delta_x <= zero_delta ? '0 : sub_res;
          state   <= ST_DY;
        end
        ST_DY: begin
          delta_y        <= zero_delta ? '0 : sub_res;
          out_contact_id <= id_q;
          out_device     <= dev_q;
          out_phase      <= ph_q;
          out_x          <= x_q;
          out_y          <= y_q;
          out_pressure   <= prs_q;
          table_full     <= !hit_found && !end_phase && !free_found;
          last_result    <= 1'b1;
          result_strobe  <= 1'b1;
          if (slot_sel) begin
            valid[ram_waddr] <= !end_phase;
          end
          state <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (issue_pend) begin
            issue_cnt         <= issue_cnt + CW'(1);
            valid[issue_addr] <= 1'b0;
          end
          cmp_vld        <= issue_pend;
          cmp_idx        <= issue_addr;
          cmp_slot_valid <= valid[issue_addr];
          cmp_last       <= issue_last;
          if (cmp_vld) begin
            if (cmp_slot_valid) begin
              out_contact_id <= rd_entry.id;
              out_device     <= rd_entry.dev;
              out_phase      <= PH_CANCEL;
              out_x          <= rd_entry.x;
              out_y          <= rd_entry.y;
              delta_x        <= '0;
              delta_y        <= '0;
              out_pressure   <= '0;
              table_full     <= 1'b0;
              last_result    <= cmp_last;
              result_strobe  <= 1'b1;
            end
            if (cmp_idx == LAST_SLOT) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted word always occupies the sequencer, raising busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  // Only a focus-lost sweep produces words that are not the final one.
  a_nonlast_flush: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |-> (state == ST_FLUSH))
    else $error("non-final result outside a focus-lost sweep");

  // A rejected insert reports no motion.
  a_full_no_delta: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && table_full) |-> (delta_x == '0 && delta_y == '0))
    else $error("table full result carries a nonzero delta");

  // A focus-lost sweep leaves the table empty.
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FLUSH) ##1 (state == ST_IDLE)) |-> (valid == '0))
    else $error("contacts remain after a focus-lost sweep");

endmodule

@@ hdl/pct_ram.sv @@
// ----------------------------------------------------------------------------
// Pointer contact tracker RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/pct_checker.sv @@
// ----------------------------------------------------------------------------
// Pointer contact tracker checker
// Watches the command and result ports of the tracker, keeps its own copy of
// the contact table, predicts the result words of every accepted word and
// compares them field by field in arrival order.
// ----------------------------------------------------------------------------
module pct_checker
  import pct_pkg::*;
#(
  parameter int MAX_CONTACTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      opcode,
  input  logic [ID_W-1:0]           contact_id,
  input  logic [DEV_W-1:0]          device_kind,
  input  logic [PHASE_W-1:0]        phase,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic [PRS_W-1:0]          pressure,
  input  logic                      result_strobe,
  input  logic [ID_W-1:0]           out_contact_id,
  input  logic [DEV_W-1:0]          out_device,
  input  logic [PHASE_W-1:0]        out_phase,
  input  logic signed [POS_W-1:0]   out_x,
  input  logic signed [POS_W-1:0]   out_y,
  input  logic signed [DELTA_W-1:0] delta_x,
  input  logic signed [DELTA_W-1:0] delta_y,
  input  logic [PRS_W-1:0]          out_pressure,
  input  logic                      table_full,
  input  logic                      last_result,
  output int                        fail_count,
  output int                        pending,
  output int                        checked,
  output int                        full_seen
);

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [DEV_W-1:0]        dev;
    logic [PHASE_W-1:0]      ph;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [DELTA_W-1:0]      dx;
    logic [DELTA_W-1:0]      dy;
    logic [PRS_W-1:0]        prs;
    logic                    full;
    logic                    last;
  } contact_report_t;

  contact_report_t expected_reports[$];
  contact_report_t head;
  logic            live [MAX_CONTACTS];
  entry_t          contacts [MAX_CONTACTS];
  int              failures;
  int              words_checked;
  int              full_count;

  task automatic compare_field(input string name, input logic [DELTA_W-1:0] want,
                               input logic [DELTA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  // Updates the table copy for one accepted word and queues the reports
  // that the tracker owes for it.
  task automatic predict_contact_update(
    input logic                    op,
    input logic [ID_W-1:0]         id,
    input logic [DEV_W-1:0]        dev,
    input logic [PHASE_W-1:0]      ph,
    input logic signed [POS_W-1:0] x,
    input logic signed [POS_W-1:0] y,
    input logic [PRS_W-1:0]        prs
  );
    int                        hit;
    int                        slot;
    int                        final_slot;
    contact_report_t           r;
    logic signed [DELTA_W-1:0] now_x;
    logic signed [DELTA_W-1:0] now_y;
    logic signed [DELTA_W-1:0] was_x;
    logic signed [DELTA_W-1:0] was_y;
    if (op == OP_FOCUS_LOST) begin
      final_slot = -1;
      for (int i = 0; i < MAX_CONTACTS; i++)
        if (live[i]) final_slot = i;
      for (int i = 0; i < MAX_CONTACTS; i++) begin
        if (live[i]) begin
          r      = '0;
          r.id   = contacts[i].id;
          r.dev  = contacts[i].dev;
          r.ph   = PH_CANCEL;
          r.x    = contacts[i].x;
          r.y    = contacts[i].y;
          r.last = (i == final_slot);
          expected_reports.push_back(r);
          live[i] = 1'b0;
        end
      end
    end else begin
      hit  = -1;
      slot = -1;
      for (int i = 0; i < MAX_CONTACTS; i++)
        if (hit < 0 && live[i] && contacts[i].id == id && contacts[i].dev == dev) hit = i;
      r      = '0;
      r.id   = id;
      r.dev  = dev;
      r.ph   = ph;
      r.x    = x;
      r.y    = y;
      r.prs  = prs;
      r.last = 1'b1;
      if (hit >= 0) begin
        if (ph != PH_DOWN) begin
          now_x = x;
          now_y = y;
          was_x = $signed(contacts[hit].x);
          was_y = $signed(contacts[hit].y);
          r.dx  = now_x - was_x;
          r.dy  = now_y - was_y;
        end
        slot = hit;
      end else if (ph == PH_DOWN || ph == PH_MOVE) begin
        for (int i = 0; i < MAX_CONTACTS; i++)
          if (slot < 0 && !live[i]) slot = i;
        if (slot >= 0) begin
          live[slot]         = 1'b1;
          contacts[slot].id  = id;
          contacts[slot].dev = dev;
        end else begin
          r.full = 1'b1;
        end
      end
      if (slot >= 0) begin
        contacts[slot].x = x;
        contacts[slot].y = y;
        if (ph == PH_UP || ph == PH_CANCEL) live[slot] = 1'b0;
      end
      expected_reports.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CONTACTS; i++) live[i] = 1'b0;
      expected_reports.delete();
      failures      = 0;
      words_checked = 0;
      full_count    = 0;
    end else begin
      // Results belong to earlier words, so they are matched before the
      // word accepted at this edge adds its own expectations.
      if (result_strobe) begin
        if (expected_reports.size() == 0) begin
          $error("result word for contact %h arrived with nothing expected", out_contact_id);
          failures++;
        end else begin
          head = expected_reports.pop_front();
          compare_field("out_contact_id", head.id, out_contact_id);
          compare_field("out_device", head.dev, out_device);
          compare_field("out_phase", head.ph, out_phase);
          compare_field("out_x", head.x, out_x);
          compare_field("out_y", head.y, out_y);
          compare_field("delta_x", head.dx, delta_x);
          compare_field("delta_y", head.dy, delta_y);
          compare_field("out_pressure", head.prs, out_pressure);
          compare_field("table_full", head.full, table_full);
          compare_field("last_result", head.last, last_result);
          words_checked++;
          if (head.full) full_count++;
        end
      end
      if (start && !busy)
        predict_contact_update(opcode, contact_id, device_kind, phase, pos_x, pos_y, pressure);
    end
    fail_count <= failures;
    pending    <= expected_reports.size();
    checked    <= words_checked;
    full_seen  <= full_count;
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pointer contact tracker testbench
// Drives directed and random command words into the tracker, with random gaps
// on the command side, and lets the checker beside the block judge every
// result word.
// ----------------------------------------------------------------------------
module tb_top
  import pct_pkg::*;
();

  localparam int MAX_CONTACTS = 16;
  localparam int KEYS         = 20;
  localparam int RANDOM_WORDS = 445;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      opcode = OP_POINTER;
  logic [ID_W-1:0]           contact_id = '0;
  logic [DEV_W-1:0]          device_kind = '0;
  logic [PHASE_W-1:0]        phase = PH_DOWN;
  logic signed [POS_W-1:0]   pos_x = '0;
  logic signed [POS_W-1:0]   pos_y = '0;
  logic [PRS_W-1:0]          pressure = '0;
  logic                      result_strobe;
  logic [ID_W-1:0]           out_contact_id;
  logic [DEV_W-1:0]          out_device;
  logic [PHASE_W-1:0]        out_phase;
  logic signed [POS_W-1:0]   out_x;
  logic signed [POS_W-1:0]   out_y;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [PRS_W-1:0]          out_pressure;
  logic                      table_full;
  logic                      last_result;
  int                        fail_count;
  int                        pending;
  int                        checked;
  int                        full_seen;

  logic [ID_W-1:0]  key_id [KEYS];
  logic [DEV_W-1:0] key_dev [KEYS];
  bit               gaps_on = 1'b0;
  int               words_sent = 0;
  int               focus_sent = 0;

  pointer_contact_tracker_top #(.MAX_CONTACTS(MAX_CONTACTS)) dut (.*);
  pct_checker #(.MAX_CONTACTS(MAX_CONTACTS)) u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("pointer_contact_tracker_top verification failed");
    $finish;
  end

  // Presents one word and returns at the edge that takes it. A random gap
  // may open first; its length spans the whole busy window of the block.
  task automatic send_word(
    input logic                    op,
    input logic [ID_W-1:0]         id,
    input logic [DEV_W-1:0]        dev,
    input logic [PHASE_W-1:0]      ph,
    input logic signed [POS_W-1:0] x,
    input logic signed [POS_W-1:0] y,
    input logic [PRS_W-1:0]        prs
  );
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_CONTACTS + 8)) @(posedge clk);
    end
    start       <= 1'b1;
    opcode      <= op;
    contact_id  <= id;
    device_kind <= dev;
    phase       <= ph;
    pos_x       <= x;
    pos_y       <= y;
    pressure    <= prs;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (op == OP_FOCUS_LOST) focus_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h7FFF_FFFF;
    if (r == 1) return 32'h8000_0000;
    if (r == 2) return '0;
    if (r < 7) return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    return $urandom;
  endfunction

  // While filling, downs and moves dominate so the table runs full; while
  // draining, ups and cancels free slots again.
  function automatic logic [PHASE_W-1:0] pick_phase(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 45) return PH_DOWN;
      if (r < 85) return PH_MOVE;
      if (r < 95) return PH_UP;
      return PH_CANCEL;
    end
    if (r < 15) return PH_DOWN;
    if (r < 50) return PH_MOVE;
    if (r < 85) return PH_UP;
    return PH_CANCEL;
  endfunction

  initial begin
    int n;
    int r;
    int k;
    bit filling;
    for (int i = 0; i < KEYS; i++) begin
      key_id[i]  = $urandom;
      key_dev[i] = DEV_W'($urandom_range(0, 15));
    end
    // Keys that differ only in device, only in id, or only in the lowest id bit.
    key_id[0]  = '0;
    key_dev[0] = '0;
    key_id[1]  = '0;
    key_dev[1] = 4'hF;
    key_id[2]  = 32'hFFFF_FFFF;
    key_dev[2] = '0;
    key_id[3]  = key_id[4] ^ 32'h1;
    key_dev[3] = key_dev[4];

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    send_word(OP_FOCUS_LOST, $urandom, 4'hF, PH_MOVE, '1, '1, '1);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'hFFFF);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_MOVE, 32'h8000_0000, 32'h8000_0000,
              16'h0000);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_MOVE, 32'h7FFF_FFFF, 32'h8000_0000,
              16'h8000);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_DOWN, 32'h0001_0000, -32'sh0001_0000,
              16'h1234);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_UP, 32'h0002_0000, 32'h0, 16'h0001);
    send_word(OP_POINTER, 32'hFFFF_FFFF, 4'hF, PH_UP, 32'h0003_0000, 32'h0, 16'h0002);
    send_word(OP_POINTER, 32'h0, 4'h0, PH_CANCEL, 32'h0, 32'h0, 16'h0);
    // Sixteen downs fill every slot, and one more contact finds no room.
    for (int i = 0; i <= MAX_CONTACTS; i++)
      send_word(OP_POINTER, key_id[i], key_dev[i], PH_DOWN, pick_pos(), pick_pos(),
                PRS_W'($urandom));
    send_word(OP_FOCUS_LOST, '0, '0, PH_DOWN, '0, '0, '0);
    wait_drained();

    // Random part: key-pool traffic with some noise and occasional focus loss.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      filling = ((n / 60) % 2) == 0;
      gaps_on = !(n >= 150 && n < 270);
      if (n == 300) wait_drained();
      r = $urandom_range(0, 99);
      if (r < (filling ? 2 : 5)) begin
        send_word(OP_FOCUS_LOST, $urandom, DEV_W'($urandom_range(0, 15)),
                  PHASE_W'($urandom_range(0, 3)), $urandom, $urandom, PRS_W'($urandom));
      end else if (r < 13) begin
        send_word(OP_POINTER, $urandom, DEV_W'($urandom_range(0, 15)),
                  PHASE_W'($urandom_range(0, 3)), $urandom, $urandom, PRS_W'($urandom));
      end else begin
        k = $urandom_range(0, KEYS - 1);
        send_word(OP_POINTER, key_id[k], key_dev[k], pick_phase(filling), pick_pos(),
                  pick_pos(), PRS_W'($urandom));
      end
    end

    wait_drained();
    repeat (MAX_CONTACTS + 8) @(posedge clk);
    $display("Sent %0d command words, %0d of them focus-lost; checked %0d result words,",
             words_sent, focus_sent, checked);
    $display("%0d of them reporting a full table.", full_seen);
    if (fail_count == 0 && pending == 0)
      $display("pointer_contact_tracker_top verification clean");
    else
      $display("pointer_contact_tracker_top verification failed");
    $finish;
  end

endmodule
